// ===== rtl/dual_wheel_pid_speed_control_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual-wheel PID speed control core
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_CORE_DEFINES_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that cons holds in the same cycle as ante.
`define DWPID_ASSERT_IMPLY(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Check that cons holds in the cycle after ante.
`define DWPID_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DWPID_ASSERT_IMPLY(label, ck, rst_n, ante, cons, msg)
`define DWPID_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/dwpid_pkg.sv =====
// ----------------------------------------------------------------------------
// dwpid_pkg
// Widths, constants, codes and the microcode table of the PID speed core.
// ----------------------------------------------------------------------------
`default_nettype none

package dwpid_pkg;

	localparam int unsigned CFG_IDX_W   = 3;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam int unsigned TARGET_W    = 8;
	localparam int unsigned GAIN_W      = 12;
	localparam int unsigned SPT_W       = 16;
	localparam int unsigned PERIOD_W    = 16;
	localparam int unsigned SPEED_W     = 20;
	localparam int unsigned ERR_W       = 21;
	localparam int unsigned INTEG_W     = 16;
	localparam int unsigned INTEG_SUM_W = 27;
	localparam int unsigned DUTY_W      = 7;
	localparam int unsigned CMP_W       = 16;
	localparam int unsigned ACC_W       = 36;
	localparam int unsigned MUL_A_W     = 24;
	localparam int unsigned MUL_B_W     = 22;
	localparam int unsigned PROD_W      = MUL_A_W + MUL_B_W;
	localparam int unsigned QSUM_W      = 48;
	localparam int unsigned RECIP_W     = 12;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam int unsigned PROG_LEN    = 12;
	localparam int unsigned PC_W        = $clog2(PROG_LEN);

	localparam logic [SPEED_W-1:0] SPEED_MAX   = 20'hFFFFF;
	localparam int                 INTEG_LIMIT = 25600;
	localparam logic [DUTY_W-1:0]  DUTY_MAX    = 7'd100;

	// ceil(2^30 / 100) split into two 12-bit halves
	localparam logic [RECIP_W-1:0] RECIP_HI = 12'hA3D;
	localparam logic [RECIP_W-1:0] RECIP_LO = 12'h70B;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET_LEFT  = 3'd0,
		REG_TARGET_RIGHT = 3'd1,
		REG_GAIN_PROP    = 3'd2,
		REG_GAIN_INTEG   = 3'd3,
		REG_GAIN_DERIV   = 3'd4,
		REG_SPEED_TICK   = 3'd5,
		REG_PWM_PERIOD   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_SPEED,
		MUL_PROP,
		MUL_DERIV,
		MUL_INTEG,
		MUL_DUTY,
		MUL_RHI,
		MUL_RLO
	} mul_sel_t;

	typedef enum logic [3:0] {
		WB_NONE,
		WB_SPEED,
		WB_ACC_INIT,
		WB_ADD_P,
		WB_SUB_D,
		WB_INTEG,
		WB_ADD_I,
		WB_PCT,
		WB_X,
		WB_QHI,
		WB_CMP
	} wb_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		wb_op_t   wb_op;
		logic     last;
	} ucode_t;

	// One wheel's program. The product of a step is consumed by the next step.
	function automatic ucode_t ucode_rom(logic [PC_W-1:0] pc);
		ucode_t uc;
		uc = '{mul_sel: MUL_NONE, wb_op: WB_NONE, last: 1'b0};
		case (pc)
			PC_W'(0):  uc = '{mul_sel: MUL_SPEED, wb_op: WB_NONE,     last: 1'b0};
			PC_W'(1):  uc = '{mul_sel: MUL_NONE,  wb_op: WB_SPEED,    last: 1'b0};
			PC_W'(2):  uc = '{mul_sel: MUL_PROP,  wb_op: WB_ACC_INIT, last: 1'b0};
			PC_W'(3):  uc = '{mul_sel: MUL_DERIV, wb_op: WB_ADD_P,    last: 1'b0};
			PC_W'(4):  uc = '{mul_sel: MUL_INTEG, wb_op: WB_SUB_D,    last: 1'b0};
			PC_W'(5):  uc = '{mul_sel: MUL_NONE,  wb_op: WB_INTEG,    last: 1'b0};
			PC_W'(6):  uc = '{mul_sel: MUL_NONE,  wb_op: WB_ADD_I,    last: 1'b0};
			PC_W'(7):  uc = '{mul_sel: MUL_NONE,  wb_op: WB_PCT,      last: 1'b0};
			PC_W'(8):  uc = '{mul_sel: MUL_DUTY,  wb_op: WB_NONE,     last: 1'b0};
			PC_W'(9):  uc = '{mul_sel: MUL_RHI,   wb_op: WB_X,        last: 1'b0};
			PC_W'(10): uc = '{mul_sel: MUL_RLO,   wb_op: WB_QHI,      last: 1'b0};
			PC_W'(11): uc = '{mul_sel: MUL_NONE,  wb_op: WB_CMP,      last: 1'b1};
			default:   uc = '{mul_sel: MUL_NONE,  wb_op: WB_NONE,     last: 1'b1};
		endcase
		return uc;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/dual_wheel_pid_speed_control_core.sv =====
// ----------------------------------------------------------------------------
// dual_wheel_pid_speed_control_core
// Two-wheel PID speed loop with integral clamp and PWM compare scaling.
// ----------------------------------------------------------------------------
// Each input transaction carries the encoder tick counts of both wheels for
// one control period; each output transaction returns the PWM compare value
// and the clamped duty percent of both wheels. A microcoded sequencer runs a
// 12-step program once per wheel on one shared 24x22 signed multiplier; a new
// transaction is accepted only after both wheels have finished the previous
// one. The result sits in an output register, so the next transaction is
// accepted and processed while it waits; the sequencer holds on its final
// step only if the previous result has still not been taken.
// Configuration writes are registered and are expected only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dual_wheel_pid_speed_control_core_defines.svh"

module dual_wheel_pid_speed_control_core #(
	parameter int unsigned TICK_WIDTH = 12
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [dwpid_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dwpid_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [TICK_WIDTH-1:0]               left_ticks,
	input  logic [TICK_WIDTH-1:0]               right_ticks,
	// output channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [dwpid_pkg::CMP_W-1:0]         left_compare,
	output logic [dwpid_pkg::CMP_W-1:0]         right_compare,
	output logic [dwpid_pkg::DUTY_W-1:0]        left_duty_percent,
	output logic [dwpid_pkg::DUTY_W-1:0]        right_duty_percent
);

	localparam int unsigned SPEED_W = dwpid_pkg::SPEED_W;
	localparam int unsigned ERR_W   = dwpid_pkg::ERR_W;
	localparam int unsigned ACC_W   = dwpid_pkg::ACC_W;
	localparam int unsigned PROD_W  = dwpid_pkg::PROD_W;
	localparam int unsigned PC_W    = dwpid_pkg::PC_W;
	localparam int unsigned ISUM_W  = dwpid_pkg::INTEG_SUM_W;
	localparam int unsigned INTEG_W = dwpid_pkg::INTEG_W;
	localparam int unsigned DUTY_W  = dwpid_pkg::DUTY_W;
	localparam int unsigned CMP_W   = dwpid_pkg::CMP_W;
	localparam int unsigned QSUM_W  = dwpid_pkg::QSUM_W;

	localparam logic signed [ISUM_W-1:0]  INTEG_HI    = ISUM_W'(dwpid_pkg::INTEG_LIMIT);
	localparam logic signed [ISUM_W-1:0]  INTEG_LO    = -INTEG_HI;
	localparam logic signed [INTEG_W-1:0] INTEG_LIM16 = INTEG_W'(dwpid_pkg::INTEG_LIMIT);

	// ---- configuration registers ----
	logic [dwpid_pkg::TARGET_W-1:0] target_left_q, target_right_q;
	logic [dwpid_pkg::GAIN_W-1:0]   gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [dwpid_pkg::SPT_W-1:0]    speed_per_tick_q;
	logic [dwpid_pkg::PERIOD_W-1:0] pwm_period_q;

	// ---- sequencer control ----
	logic                busy_q;
	logic [PC_W-1:0]     pc_q;
	logic                wheel_q;
	logic                out_valid_q;
	dwpid_pkg::ucode_t   uc;
	logic                final_step;
	logic                out_free;
	logic                adv;
	logic                in_take;

	// ---- per-wheel loop state ----
	logic [SPEED_W-1:0]        prev_speed_q [2];
	logic signed [INTEG_W-1:0] integ_acc_q  [2];
	logic [DUTY_W-1:0]         duty_acc_q   [2];

	// ---- datapath registers ----
	logic [TICK_WIDTH-1:0]     ticks_q [2];
	logic [SPEED_W-1:0]        speed_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic [22:0]               x_q;
	logic [QSUM_W-1:0]         q_hi_q;
	logic [CMP_W-1:0]          left_cmp_q;
	logic [CMP_W-1:0]          left_compare_q, right_compare_q;
	logic [DUTY_W-1:0]         left_duty_q, right_duty_q;

	// ---- datapath nets ----
	logic [dwpid_pkg::TARGET_W-1:0]       target_sel;
	logic signed [ERR_W-1:0]              err;
	logic signed [ERR_W-1:0]              diff;
	logic signed [dwpid_pkg::MUL_A_W-1:0] mul_a;
	logic signed [dwpid_pkg::MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]             mul_p;
	logic [SPEED_W-1:0]                   speed_next;
	logic signed [ISUM_W-1:0]             integ_sum;
	logic signed [INTEG_W-1:0]            integ_next;
	logic [DUTY_W-1:0]                    pct_next;
	logic [QSUM_W-1:0]                    q_sum;
	logic [CMP_W-1:0]                     cmp_next;

	// ---- sequencing ----
	assign uc         = dwpid_pkg::ucode_rom(pc_q);
	assign final_step = uc.last && wheel_q;
	assign out_free   = !out_valid_q || out_ready;
	// hold on the final step until the output register is free
	assign adv        = busy_q && (!final_step || out_free);
	assign in_ready   = !busy_q;
	assign in_take    = in_valid && !busy_q;

	// ---- per-step operands ----
	assign target_sel = wheel_q ? target_right_q : target_left_q;
	// error and speed delta in Q.8
	assign err  = $signed({5'b0, target_sel, 8'b0}) - $signed({1'b0, speed_q});
	assign diff = $signed({1'b0, speed_q}) - $signed({1'b0, prev_speed_q[wheel_q]});

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (uc.mul_sel)
			dwpid_pkg::MUL_SPEED: begin
				mul_a = {{(dwpid_pkg::MUL_A_W-TICK_WIDTH){1'b0}}, ticks_q[wheel_q]};
				mul_b = {6'b0, speed_per_tick_q};
			end
			dwpid_pkg::MUL_PROP: begin
				mul_a = {12'b0, gain_prop_q};
				mul_b = {err[ERR_W-1], err};
			end
			dwpid_pkg::MUL_DERIV: begin
				mul_a = {12'b0, gain_deriv_q};
				mul_b = {diff[ERR_W-1], diff};
			end
			dwpid_pkg::MUL_INTEG: begin
				mul_a = {12'b0, gain_integ_q};
				mul_b = {err[ERR_W-1], err};
			end
			dwpid_pkg::MUL_DUTY: begin
				mul_a = {8'b0, pwm_period_q};
				mul_b = {15'b0, duty_acc_q[wheel_q]};
			end
			// reciprocal of 100, high half, applied to period * percent
			dwpid_pkg::MUL_RHI: begin
				mul_a = {1'b0, prod_q[22:0]};
				mul_b = {10'b0, dwpid_pkg::RECIP_HI};
			end
			dwpid_pkg::MUL_RLO: begin
				mul_a = {1'b0, x_q};
				mul_b = {10'b0, dwpid_pkg::RECIP_LO};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// ---- write-back values ----
	// speed = (ticks * speed_per_tick) >> 8, saturated to 20 bits
	assign speed_next = (|prod_q[PROD_W-1:SPEED_W+8]) ? dwpid_pkg::SPEED_MAX
	                                                   : prod_q[SPEED_W+7:8];

	// arithmetic shift by 8 floors the integral increment
	assign integ_sum = $signed({{(ISUM_W-INTEG_W){integ_acc_q[wheel_q][INTEG_W-1]}},
	                            integ_acc_q[wheel_q]}) + $signed(prod_q[ISUM_W+7:8]);

	always_comb begin
		if (integ_sum > INTEG_HI) begin
			integ_next = INTEG_LIM16;
		end else if (integ_sum < INTEG_LO) begin
			integ_next = -INTEG_LIM16;
		end else begin
			integ_next = integ_sum[INTEG_W-1:0];
		end
	end

	// negative totals truncate to zero or below, so clamp them to zero; clamp totals above 100 to 100
	always_comb begin
		if (acc_q[ACC_W-1]) begin
			pct_next = '0;
		end else if (acc_q[ACC_W-2:16] > 19'd100) begin
			pct_next = dwpid_pkg::DUTY_MAX;
		end else begin
			pct_next = acc_q[16+DUTY_W-1:16];
		end
	end

	// floor(x / 100) = (x * ceil(2^30 / 100)) >> 30 for x below 2^23
	assign q_sum    = q_hi_q + {2'b0, prod_q};
	assign cmp_next = q_sum[dwpid_pkg::RECIP_SHIFT+CMP_W-1:dwpid_pkg::RECIP_SHIFT];

	// ---- control and loop state ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q           <= 1'b0;
			pc_q             <= '0;
			wheel_q          <= 1'b0;
			out_valid_q      <= 1'b0;
			target_left_q    <= 8'd6;
			target_right_q   <= 8'd6;
			gain_prop_q      <= 12'd1024;
			gain_integ_q     <= 12'd512;
			gain_deriv_q     <= 12'd1024;
			speed_per_tick_q <= 16'd37431;
			pwm_period_q     <= 16'd2250;
			prev_speed_q[0]  <= '0;
			prev_speed_q[1]  <= '0;
			integ_acc_q[0]   <= '0;
			integ_acc_q[1]   <= '0;
			duty_acc_q[0]    <= '0;
			duty_acc_q[1]    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					dwpid_pkg::REG_TARGET_LEFT:  target_left_q    <= cfg_data[7:0];
					dwpid_pkg::REG_TARGET_RIGHT: target_right_q   <= cfg_data[7:0];
					dwpid_pkg::REG_GAIN_PROP:    gain_prop_q      <= cfg_data[11:0];
					dwpid_pkg::REG_GAIN_INTEG:   gain_integ_q     <= cfg_data[11:0];
					dwpid_pkg::REG_GAIN_DERIV:   gain_deriv_q     <= cfg_data[11:0];
					dwpid_pkg::REG_SPEED_TICK:   speed_per_tick_q <= cfg_data;
					dwpid_pkg::REG_PWM_PERIOD:   pwm_period_q     <= cfg_data;
					default: ;
				endcase
			end

			// raise valid when the right wheel finishes; otherwise drop the
			// result once taken
			if (adv && final_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (in_take) begin
				busy_q  <= 1'b1;
				pc_q    <= '0;
				wheel_q <= 1'b0;
			end else if (adv) begin
				if (uc.last) begin
					pc_q <= '0;
					if (!wheel_q) begin
						wheel_q <= 1'b1;
					end else begin
						wheel_q <= 1'b0;
						busy_q  <= 1'b0;
					end
				end else begin
					pc_q <= pc_q + PC_W'(1);
				end

				case (uc.wb_op)
					dwpid_pkg::WB_INTEG: integ_acc_q[wheel_q] <= integ_next;
					dwpid_pkg::WB_PCT: begin
						duty_acc_q[wheel_q]   <= pct_next;
						prev_speed_q[wheel_q] <= speed_q;
					end
					default: ;
				endcase
			end
		end
	end

	// ---- datapath payload ----
	always_ff @(posedge clk) begin
		if (in_take) begin
			ticks_q[0] <= left_ticks;
			ticks_q[1] <= right_ticks;
		end

		if (adv) begin
			prod_q <= mul_p;
			case (uc.wb_op)
				dwpid_pkg::WB_SPEED:    speed_q <= speed_next;
				dwpid_pkg::WB_ACC_INIT: acc_q   <= $signed({13'b0, duty_acc_q[wheel_q], 16'b0});
				dwpid_pkg::WB_ADD_P:    acc_q   <= acc_q + $signed(prod_q[ACC_W-1:0]);
				dwpid_pkg::WB_SUB_D:    acc_q   <= acc_q - $signed(prod_q[ACC_W-1:0]);
				dwpid_pkg::WB_ADD_I: begin
					acc_q <= acc_q + $signed({{12{integ_acc_q[wheel_q][INTEG_W-1]}},
					                          integ_acc_q[wheel_q], 8'b0});
				end
				dwpid_pkg::WB_X:        x_q     <= prod_q[22:0];
				dwpid_pkg::WB_QHI:      q_hi_q  <= {prod_q[35:0], 12'b0};
				dwpid_pkg::WB_CMP: begin
					if (!wheel_q) begin
						left_cmp_q <= cmp_next;
					end
				end
				default: ;
			endcase

			// load the output register on the final step of the right wheel
			if (final_step) begin
				left_compare_q  <= left_cmp_q;
				right_compare_q <= cmp_next;
				left_duty_q     <= duty_acc_q[0];
				right_duty_q    <= duty_acc_q[1];
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign left_compare       = left_compare_q;
	assign right_compare      = right_compare_q;
	assign left_duty_percent  = left_duty_q;
	assign right_duty_percent = right_duty_q;

	// ---- assertions ----
	`DWPID_ASSERT_NEXT(a_start_clean, clk, arst_n, in_valid && in_ready, busy_q && (pc_q == '0) && !wheel_q, "transaction did not start the program at step zero on the left wheel")
	`DWPID_ASSERT_NEXT(a_final_hold, clk, arst_n, busy_q && final_step && out_valid && !out_ready, busy_q && wheel_q && (pc_q == $past(pc_q)), "sequencer left its final step while the output was blocked")
	`DWPID_ASSERT_IMPLY(a_duty_range, clk, arst_n, out_valid, (left_duty_percent <= dwpid_pkg::DUTY_MAX) && (right_duty_percent <= dwpid_pkg::DUTY_MAX), "duty percent above limit")
	`DWPID_ASSERT_IMPLY(a_integ_bound, clk, arst_n, 1'b1, (integ_acc_q[0] <= INTEG_LIM16) && (integ_acc_q[0] >= -INTEG_LIM16) && (integ_acc_q[1] <= INTEG_LIM16) && (integ_acc_q[1] >= -INTEG_LIM16), "integral outside clamp range")

endmodule

`default_nettype wire
